// ===== rtl/core/dps_pkg.sv =====
// dps_pkg: shared types and constants of the dynamic priority scheduler
// used by dps_cell and dynamic_priority_scheduler, depends on nothing
package dps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int OCC_W     = $clog2(MAX_PROCS + 1);
    localparam int QLEN_W    = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_LOADED   = 3'd0,
        ST_REQUEUED = 3'd1,
        ST_FINISHED = 3'd2,
        ST_IDLE     = 3'd3,
        ST_DROPPED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_INS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT
    } t_cmd;

    typedef struct packed {
        logic [7:0]         id;
        logic signed [15:0] prio;
        logic [15:0]        need;
        logic [15:0]        runs;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [7:0]         id;
        logic signed [15:0] prio;
        logic [15:0]        runs;
        logic [15:0]        left;
    } t_result;

endpackage

// ===== rtl/core/dps_cell.sv =====
// dps_cell: one slot of the sorted ready queue
// depends on dps_pkg for the entry and command types
module dps_cell (
    input  logic            i_clk,
    input  dps_pkg::t_cmd   i_cmd,
    input  logic            i_valid,
    input  dps_pkg::t_entry i_new,
    input  dps_pkg::t_entry i_left,
    input  logic            i_left_keep,
    input  dps_pkg::t_entry i_right,
    output dps_pkg::t_entry o_entry,
    output logic            o_keep
);

    dps_pkg::t_entry r_entry;
    dps_pkg::t_entry n_entry;

    // stays put when it is ahead of the incoming word (equal counts as ahead)
    assign o_keep = i_valid && (r_entry.prio >= i_new.prio);

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd)
            dps_pkg::CMD_HOLD:   n_entry = r_entry;
            dps_pkg::CMD_INSERT: begin
                if (o_keep) begin
                    n_entry = r_entry;
                end else if (i_left_keep) begin
                    n_entry = i_new;
                end else begin
                    n_entry = i_left;
                end
            end
            dps_pkg::CMD_SHIFT:  n_entry = i_right;
            default:             n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/dynamic_priority_scheduler.sv =====
// dynamic_priority_scheduler: ready queue as a chain of dps_cell slots plus control
// depends on dps_pkg and dps_cell
//
//  channel  | valid      | ready       | payload
//  ---------+------------+-------------+--------------------------------------------
//  input    | i_in_valid | o_in_ready  | i_operation i_proc_id i_prio_in i_need_time
//  output   | o_out_valid| i_out_ready | o_status o_ran_id o_prio_out o_ran_slices
//           |            |             | o_left_slices o_slice_number o_queue_len
//
// a load goes through accept, an insert pass through the chain and result, a tick that
// requeues through accept, shift out the head, insert and result, a tick that finishes
// skips the insert, and a full drop or an idle tick goes from accept straight to result
// reset is synchronous active low, clears the fill count, slice count and handshakes
// a word is accepted only in the idle state; a finished result waits in the output
// register and the next word is taken meanwhile, its own result waits for the register
// queue slots hold no reset; only the first fill-count slots hold valid entries
module dynamic_priority_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [7:0]         i_proc_id,
    input  logic signed [15:0] i_prio_in,
    input  logic [15:0]        i_need_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [7:0]         o_ran_id,
    output logic signed [15:0] o_prio_out,
    output logic [15:0]        o_ran_slices,
    output logic [15:0]        o_left_slices,
    output logic [15:0]        o_slice_number,
    output logic [4:0]         o_queue_len
);

    localparam int N = dps_pkg::MAX_PROCS;

    dps_pkg::t_state r_state;
    dps_pkg::t_state n_state;

    logic [dps_pkg::OCC_W-1:0] r_count;
    logic [dps_pkg::OCC_W-1:0] n_count;
    logic [15:0]               r_slice;
    logic [15:0]               n_slice;

    // word being placed and the result under construction
    dps_pkg::t_entry  r_ent;
    dps_pkg::t_entry  n_ent;
    dps_pkg::t_result r_res;
    dps_pkg::t_result n_res;
    logic             r_need_ins;
    logic             n_need_ins;

    // output register
    logic             r_out_valid;
    dps_pkg::t_result r_out;
    logic [15:0]      r_out_slice;
    logic [4:0]       r_out_qlen;

    // chain wiring
    dps_pkg::t_cmd   cell_cmd;
    dps_pkg::t_entry cell_ent  [N];
    logic            cell_keep [N];
    logic            cell_valid[N];

    logic in_fire;
    logic out_load;
    logic queue_full;

    // head after its slice
    dps_pkg::t_entry    head;
    logic signed [15:0] head_prio;
    logic [15:0]        head_runs;
    logic [15:0]        need_eff;

    assign in_fire    = i_in_valid && o_in_ready;
    assign queue_full = (r_count >= dps_pkg::OCC_W'(N));
    assign need_eff   = (i_need_time == 16'd0) ? 16'd1 : i_need_time;

    assign head      = cell_ent[0];
    assign head_prio = (head.prio == 16'sh8000) ? head.prio : head.prio - 16'sd1;
    assign head_runs = (head.runs < head.need) ? head.runs + 16'd1 : head.runs;

    // ---------------- cell chain ----------------
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            dps_pkg::t_entry left_ent;
            logic            left_keep;
            dps_pkg::t_entry right_ent;

            assign cell_valid[k] = (dps_pkg::OCC_W'(k) < r_count);

            if (k == 0) begin : g_first
                assign left_ent  = r_ent;
                assign left_keep = 1'b0;
            end else begin : g_mid
                assign left_ent  = cell_ent[k-1];
                assign left_keep = cell_keep[k-1];
            end

            if (k == N - 1) begin : g_last
                assign right_ent = cell_ent[k];
            end else begin : g_inner
                assign right_ent = cell_ent[k+1];
            end

            dps_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (cell_cmd),
                .i_valid     (cell_valid[k]),
                .i_new       (r_ent),
                .i_left      (left_ent),
                .i_left_keep (left_keep),
                .i_right     (right_ent),
                .o_entry     (cell_ent[k]),
                .o_keep      (cell_keep[k])
            );
        end
    endgenerate

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dps_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_operation == dps_pkg::OP_LOAD) begin
                        n_state = queue_full ? dps_pkg::S_DONE : dps_pkg::S_INS;
                    end else begin
                        n_state = (r_count == '0) ? dps_pkg::S_DONE : dps_pkg::S_POP;
                    end
                end
            end
            dps_pkg::S_POP: begin
                n_state = (head_runs >= head.need) ? dps_pkg::S_DONE : dps_pkg::S_INS;
            end
            dps_pkg::S_INS:  n_state = dps_pkg::S_DONE;
            dps_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = dps_pkg::S_IDLE;
                end
            end
            default: n_state = dps_pkg::S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_in_ready = 1'b0;
        cell_cmd   = dps_pkg::CMD_HOLD;
        out_load   = 1'b0;
        unique case (r_state)
            dps_pkg::S_IDLE: o_in_ready = 1'b1;
            dps_pkg::S_POP:  cell_cmd   = dps_pkg::CMD_SHIFT;
            dps_pkg::S_INS:  cell_cmd   = dps_pkg::CMD_INSERT;
            dps_pkg::S_DONE: out_load   = !r_out_valid || i_out_ready;
            default:         o_in_ready = 1'b0;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        n_ent      = r_ent;
        n_res      = r_res;
        n_count    = r_count;
        n_slice    = r_slice;
        n_need_ins = r_need_ins;

        if (r_state == dps_pkg::S_IDLE && in_fire) begin
            n_res.id   = 8'd0;
            n_res.prio = 16'sd0;
            n_res.runs = 16'd0;
            n_res.left = 16'd0;
            if (i_operation == dps_pkg::OP_LOAD) begin
                n_res.id = i_proc_id;
                if (queue_full) begin
                    n_res.status = dps_pkg::ST_DROPPED;
                end else begin
                    n_res.status = dps_pkg::ST_LOADED;
                    n_res.prio   = i_prio_in;
                    n_res.left   = need_eff;
                    n_ent.id     = i_proc_id;
                    n_ent.prio   = i_prio_in;
                    n_ent.need   = need_eff;
                    n_ent.runs   = 16'd0;
                end
            end else begin
                n_res.status = dps_pkg::ST_IDLE;
            end
        end

        if (r_state == dps_pkg::S_POP) begin
            n_count    = r_count - 1'b1;
            n_slice    = r_slice + 16'd1;
            n_res.id   = head.id;
            n_res.prio = head_prio;
            n_res.runs = head_runs;
            n_res.left = head.need - head_runs;
            n_res.status = (head_runs >= head.need) ? dps_pkg::ST_FINISHED
                                                    : dps_pkg::ST_REQUEUED;
            n_ent.id   = head.id;
            n_ent.prio = head_prio;
            n_ent.need = head.need;
            n_ent.runs = head_runs;
        end

        if (r_state == dps_pkg::S_INS) begin
            n_count = r_count + 1'b1;
        end

        n_need_ins = (n_state == dps_pkg::S_INS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dps_pkg::S_IDLE;
            r_count     <= '0;
            r_slice     <= 16'd0;
            r_out_valid <= 1'b0;
            r_need_ins  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_slice    <= n_slice;
            r_need_ins <= n_need_ins;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        r_res <= n_res;
        if (out_load) begin
            r_out       <= r_res;
            r_out_slice <= r_slice;
            r_out_qlen  <= dps_pkg::QLEN_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_ran_id       = r_out.id;
    assign o_prio_out     = r_out.prio;
    assign o_ran_slices   = r_out.runs;
    assign o_left_slices  = r_out.left;
    assign o_slice_number = r_out_slice;
    assign o_queue_len    = r_out_qlen;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dps_pkg::OCC_W'(N))
        else $error("fill count above queue depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dps_pkg::S_POP) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drop the fill count");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dps_pkg::S_INS) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise the fill count");

    a_slice_only_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dps_pkg::S_POP) |=> $stable(r_slice))
        else $error("slice count moved without a slice");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dps_pkg::ST_IDLE) |-> (o_queue_len == 5'd0))
        else $error("idle result with a nonempty queue");

    a_ins_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dps_pkg::S_INS) |-> (r_need_ins && !queue_full))
        else $error("insert pass on a full queue");

endmodule

// ===== sim/testbench.sv =====
// testbench for dynamic_priority_scheduler: directed and random load/tick words,
// a scoreboard class predicts every result word; depends on dps_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int PHASE_WORDS    = 173;   // random words per random phase
    localparam int DRAIN_CYCLES   = 20;    // idle cycles after the last result word

    // one predicted result word
    typedef struct {
        dps_pkg::t_status status;
        logic [7:0]       id;
        logic [15:0]      prio;
        logic [15:0]      runs;
        logic [15:0]      left;
        logic [15:0]      slice_no;
        logic [4:0]       qlen;
    } t_sched_result;

    // ready queue predictor plus the list of result words still owed
    class sched_scoreboard;
        dps_pkg::t_entry slots [dps_pkg::MAX_PROCS];
        int              fill;
        logic [15:0]     slice_cnt;
        t_sched_result   owed_q [$];
        int              errors;

        function new();
            fill      = 0;
            slice_cnt = '0;
            errors    = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // behind every entry of equal or larger priority
        function void place(dps_pkg::t_entry e);
            int pos;
            pos = 0;
            while (pos < fill && slots[pos].prio >= e.prio) pos++;
            for (int k = fill; k > pos; k--) slots[k] = slots[k - 1];
            slots[pos] = e;
            fill++;
        endfunction

        function void note_input(logic op, logic [7:0] id, logic [15:0] prio,
                                 logic [15:0] need);
            t_sched_result   r;
            dps_pkg::t_entry e;
            r.id   = '0;
            r.prio = '0;
            r.runs = '0;
            r.left = '0;
            if (op == dps_pkg::OP_LOAD) begin
                r.id = id;
                if (fill >= dps_pkg::MAX_PROCS) begin
                    r.status = dps_pkg::ST_DROPPED;
                end else begin
                    e.id   = id;
                    e.prio = prio;
                    e.need = (need == 16'd0) ? 16'd1 : need;
                    e.runs = '0;
                    place(e);
                    r.status = dps_pkg::ST_LOADED;
                    r.prio   = prio;
                    r.left   = e.need;
                end
            end else if (fill == 0) begin
                r.status = dps_pkg::ST_IDLE;
            end else begin
                e = slots[0];
                for (int k = 1; k < fill; k++) slots[k - 1] = slots[k];
                fill--;
                slice_cnt = slice_cnt + 16'd1;
                if (e.prio != 16'sh8000) e.prio = e.prio - 16'sd1;
                if (e.runs < e.need) e.runs = e.runs + 16'd1;
                if (e.runs >= e.need) begin
                    r.status = dps_pkg::ST_FINISHED;
                end else begin
                    place(e);
                    r.status = dps_pkg::ST_REQUEUED;
                end
                r.id   = e.id;
                r.prio = e.prio;
                r.runs = e.runs;
                r.left = e.need - e.runs;
            end
            r.slice_no = slice_cnt;
            r.qlen     = 5'(fill);
            owed_q.push_back(r);
        endfunction

        function void cmp_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $display("%0t mismatch on %s: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] status, logic [7:0] id,
                                   logic [15:0] prio, logic [15:0] runs,
                                   logic [15:0] left, logic [15:0] slice_no,
                                   logic [4:0] qlen);
            t_sched_result r;
            if (owed_q.size() == 0) begin
                $display("%0t result word with nothing owed: status %0d id %0d",
                         $time, status, id);
                errors++;
                return;
            end
            r = owed_q.pop_front();
            cmp_field("status", longint'(r.status), longint'(status));
            cmp_field("ran_id", r.id, id);
            cmp_field("prio_out", longint'($signed(r.prio)), longint'($signed(prio)));
            cmp_field("ran_slices", r.runs, runs);
            cmp_field("left_slices", r.left, left);
            cmp_field("slice_number", r.slice_no, slice_no);
            cmp_field("queue_len", r.qlen, qlen);
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic               i_operation    = dps_pkg::OP_LOAD;
    logic [7:0]         i_proc_id      = '0;
    logic signed [15:0] i_prio_in      = '0;
    logic [15:0]        i_need_time    = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [2:0]         o_status;
    logic [7:0]         o_ran_id;
    logic signed [15:0] o_prio_out;
    logic [15:0]        o_ran_slices;
    logic [15:0]        o_left_slices;
    logic [15:0]        o_slice_number;
    logic [4:0]         o_queue_len;

    sched_scoreboard sb = new();

    // idling knobs (percent of cycles, hold-off request) and the watchdog count
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_req      = 1'b0;
    int unsigned quiet_cycles  = 0;

    dynamic_priority_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_proc_id      (i_proc_id),
        .i_prio_in      (i_prio_in),
        .i_need_time    (i_need_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_ran_id       (o_ran_id),
        .o_prio_out     (o_prio_out),
        .o_ran_slices   (o_ran_slices),
        .o_left_slices  (o_left_slices),
        .o_slice_number (o_slice_number),
        .o_queue_len    (o_queue_len)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // both handshakes are sampled at the edge, before any update of that edge lands
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_input(i_operation, i_proc_id, i_prio_in, i_need_time);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_ran_id, o_prio_out, o_ran_slices,
                            o_left_slices, o_slice_number, o_queue_len);
    end

    // receiver: random stalls, or a long hold-off counted here when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, hold it until taken, then maybe leave a gap
    task automatic send_word(input logic op, input logic [7:0] id,
                             input logic [15:0] prio, input logic [15:0] need);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_proc_id   <= id;
        i_prio_in   <= prio;
        i_need_time <= need;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // fields of a tick are ignored by the block, so fill them with noise
    task automatic tick_word();
        send_word(dps_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_word(input int unsigned load_pct);
        logic        op;
        logic [15:0] prio;
        logic [15:0] need;
        op = ($urandom_range(99) < load_pct) ? dps_pkg::OP_LOAD : dps_pkg::OP_TICK;
        // narrow priorities give plenty of ties, the rest span the full range
        case ($urandom_range(3))
            0:       prio = 16'($urandom_range(8) - 4);
            1: begin
                case ($urandom_range(3))
                    0:       prio = 16'h7FFF;
                    1:       prio = 16'h8000;
                    2:       prio = 16'h8001;
                    default: prio = 16'h7FFE;
                endcase
            end
            default: prio = 16'($urandom);
        endcase
        // mostly short jobs so that entries finish, a few long ones hog slots
        case ($urandom_range(7))
            0:       need = '0;
            6:       need = 16'($urandom_range(40, 7));
            7:       need = 16'($urandom);
            default: need = 16'($urandom_range(6, 1));
        endcase
        send_word(op, 8'($urandom), prio, need);
    endtask

    // sender goes quiet until every owed result word is back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned load_pct;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick on an empty queue
        tick_word();
        // zero need, both priority extremes, a tie at the top
        send_word(dps_pkg::OP_LOAD, 8'h00, 16'h7FFF, 16'h0000);
        send_word(dps_pkg::OP_LOAD, 8'hFF, 16'h8000, 16'h0003);
        send_word(dps_pkg::OP_LOAD, 8'h5A, 16'h7FFF, 16'h0002);
        // drain: the last entry sits on the priority floor for three slices
        repeat (6) tick_word();
        tick_word();
        // fill the queue with mixed ties, then two loads that get dropped
        for (int k = 0; k < dps_pkg::MAX_PROCS; k++)
            send_word(dps_pkg::OP_LOAD, 8'(k * 17), 16'(k % 3 - 1),
                      (k == dps_pkg::MAX_PROCS - 1) ? 16'hFFFF : 16'(k % 4));
        send_word(dps_pkg::OP_LOAD, 8'hA5, 16'h7FFF, 16'hFFFF);
        send_word(dps_pkg::OP_LOAD, 8'h3C, 16'h8000, 16'h0000);

        // receiver holds off while words keep coming, so the input stalls
        hold_req = 1'b1;
        repeat (30) random_word(50);
        wait_all_results();

        // random phases: none, sender idle, receiver stalling, both lightly
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 8; stall_pct = 8; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // load mix swings so the queue both fills and drains
                case ((n / 25) % 3)
                    0:       load_pct = 35;
                    1:       load_pct = 75;
                    default: load_pct = 55;
                endcase
                random_word(load_pct);
            end
            wait_all_results();
        end

        i_in_valid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
